@@ rtl/assert_macros.svh @@
// Assertion macros shared by the byte FIFO RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define BFOM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop at every rising clock edge, reset included.
`define BFOM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bfom_pkg.sv @@
// Package for the byte FIFO with overflow marker: defaults, marker bytes,
// operation codes and the sequencer state type. Depends on nothing.
package bfom_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam logic [7:0] MARK_B = 8'h42;
  localparam logic [7:0] MARK_U = 8'h55;
  localparam logic [7:0] MARK_F = 8'h46;

  localparam logic ACT_PUT = 1'b0;
  localparam logic ACT_GET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GET,
    ST_MARK_U,
    ST_MARK_F
  } state_t;

endpackage

@@ rtl/byte_fifo_with_overflow_marker_unit.sv @@
// Byte FIFO with overflow marker; depends on bfom_pkg, bfom_ram and assert_macros.svh.
// Result strobe in the cycle after accept for a put or an empty get; a byte get reads
// the RAM into its read register, then ST_GET registers the result; a marker put
// writes B, U, F, one RAM write per state (IDLE, ST_MARK_U, ST_MARK_F), then strobes.
// Throughput: one put per cycle while not busy; no new word is taken during a byte
// get or a marker put. Synchronous reset empties the queue; results cannot be stalled.
`include "assert_macros.svh"

module byte_fifo_with_overflow_marker_unit #(
  parameter int unsigned DEPTH = bfom_pkg::DEPTH_DEF,
  parameter int unsigned IW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic          in_action,
  input  logic [7:0]    in_data_in,
  output logic          out_strobe,
  output logic [7:0]    out_data_out,
  output logic          out_data_valid,
  output logic          out_queue_empty,
  output logic          out_queue_full,
  output logic [CW-1:0] out_occupancy
);

  localparam logic [IW-1:0] IDX_LAST  = IW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MARK  = CW'(DEPTH - 3);
  localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);

  bfom_pkg::state_t state_r, state_nxt;

  logic [IW-1:0] wr_idx_r, wr_idx_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  logic          out_dv_r, out_dv_nxt;
  logic [7:0]    out_data_r, out_data_nxt;

  logic          accept;
  logic          is_put;
  logic          put_plain;
  logic          put_mark;
  logic          get_hit;
  logic          ram_we;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [7:0]    ram_q;

  bfom_ram #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .q_r   (ram_q)
  );

  assign busy      = (state_r != bfom_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign is_put    = (in_action == bfom_pkg::ACT_PUT);
  assign put_plain = accept && is_put && (cnt_r < CNT_MARK);
  assign put_mark  = accept && is_put && (cnt_r == CNT_MARK);
  assign get_hit   = accept && !is_put && (cnt_r != '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfom_pkg::ST_IDLE: begin
        if (put_mark) begin
          state_nxt = bfom_pkg::ST_MARK_U;
        end else if (get_hit) begin
          state_nxt = bfom_pkg::ST_GET;
        end
      end
      bfom_pkg::ST_GET:    state_nxt = bfom_pkg::ST_IDLE;
      bfom_pkg::ST_MARK_U: state_nxt = bfom_pkg::ST_MARK_F;
      bfom_pkg::ST_MARK_F: state_nxt = bfom_pkg::ST_IDLE;
      default:             state_nxt = bfom_pkg::ST_IDLE;
    endcase
  end

  // RAM control, indices, count and result.
  always_comb begin
    ram_we         = 1'b0;
    ram_wdata      = in_data_in;
    ram_re         = 1'b0;
    wr_idx_nxt     = wr_idx_r;
    rd_idx_nxt     = rd_idx_r;
    cnt_nxt        = cnt_r;
    out_strobe_nxt = 1'b0;
    out_dv_nxt     = 1'b0;
    out_data_nxt   = '0;
    unique case (state_r)
      bfom_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_put) begin
            // Marker put drops the byte and writes B first.
            ram_we    = put_plain || put_mark;
            ram_wdata = put_mark ? bfom_pkg::MARK_B : in_data_in;
            out_strobe_nxt = !put_mark;
          end else begin
            ram_re         = get_hit;
            out_strobe_nxt = !get_hit;
          end
        end
      end
      bfom_pkg::ST_GET: begin
        out_strobe_nxt = 1'b1;
        out_dv_nxt     = 1'b1;
        out_data_nxt   = ram_q;
      end
      bfom_pkg::ST_MARK_U: begin
        ram_we    = 1'b1;
        ram_wdata = bfom_pkg::MARK_U;
      end
      bfom_pkg::ST_MARK_F: begin
        ram_we         = 1'b1;
        ram_wdata      = bfom_pkg::MARK_F;
        out_strobe_nxt = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
    if (ram_we) begin
      wr_idx_nxt = (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + 1'b1;
      cnt_nxt    = cnt_r + 1'b1;
    end
    if (ram_re) begin
      rd_idx_nxt = (rd_idx_r == IDX_LAST) ? '0 : rd_idx_r + 1'b1;
      cnt_nxt    = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfom_pkg::ST_IDLE;
      wr_idx_r     <= '0;
      rd_idx_r     <= '0;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
      out_dv_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wr_idx_r     <= wr_idx_nxt;
      rd_idx_r     <= rd_idx_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_dv_r     <= out_dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Status follows the registered count, which changes when a byte is written or read.
  assign out_strobe      = out_strobe_r;
  assign out_data_out    = out_data_r;
  assign out_data_valid  = out_dv_r;
  assign out_queue_empty = (cnt_r == '0);
  assign out_queue_full  = (cnt_r == CNT_FULL);
  assign out_occupancy   = cnt_r;

  `BFOM_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CNT_FULL, "fill count above depth")
  `BFOM_ASSERT(a_idx_meet, clk, rst_n,
    (cnt_r == '0 || cnt_r == CNT_FULL) |-> (wr_idx_r == rd_idx_r),
    "indices disagree with empty or full count")
  `BFOM_ASSERT(a_get_result, clk, rst_n,
    (state_r == bfom_pkg::ST_GET) |=> (out_strobe_r && out_dv_r),
    "byte get produced no valid result")
  `BFOM_ASSERT(a_quick_result, clk, rst_n,
    (accept && !put_mark && !get_hit) |=> (out_strobe_r && !out_dv_r),
    "single-cycle word produced no result")
  `BFOM_ASSERT(a_mark_full, clk, rst_n,
    (state_r == bfom_pkg::ST_MARK_F) |=> (cnt_r == CNT_FULL),
    "marker did not fill the queue")

endmodule

@@ rtl/bfom_ram.sv @@
// Byte storage of the FIFO: one write port, one read port, registered read data.
// Depends on nothing.
module bfom_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output logic [7:0]    q_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q_r <= mem[raddr];
    end
  end

endmodule
